// File: hw/rtl/loop_subdivision_point_rule_core_defines.svh
// Assertion helpers for the Loop point-rule core.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef LOOP_SUBDIVISION_POINT_RULE_CORE_DEFINES_SVH
`define LOOP_SUBDIVISION_POINT_RULE_CORE_DEFINES_SVH

// Same-cycle implication.
`define LSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lsp_pkg.sv
package lsp_pkg;

  localparam int unsigned CoordW   = 32;  // Q16.16 coordinate
  localparam int unsigned EwSumW   = 33;  // sum of two endpoints or two wings
  localparam int unsigned NbCntW   = 7;   // neighbour count, saturates at 127
  localparam int unsigned EwCntW   = 2;   // endpoint / wing count, saturates at 3
  localparam int unsigned NumCoord = 3;

  typedef enum logic [1:0] {
    ROLE_CENTRE    = 2'd0,
    ROLE_NEIGHBOUR = 2'd1,
    ROLE_ENDPOINT  = 2'd2,
    ROLE_WING      = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_VALENCE = 2'd1,
    STATUS_MALFORMED   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    JOB_MID,     // edge midpoint
    JOB_WING,    // edge with two wings
    JOB_V2,      // boundary vertex
    JOB_V3,      // valence three
    JOB_VN       // valence above three
  } job_e;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_EVAL,
    ST_MUL,
    ST_LOAD,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic [1:0]               status;
  } res_t;

endpackage

// File: hw/rtl/lsp_div.sv
// Restoring divider, one quotient bit per cycle, truncation toward zero.
module lsp_div #(
  parameter int unsigned NumW = 41,
  parameter int unsigned DivW = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [NumW-1:0]         dividend_i,
  input  logic [DivW-1:0]                divisor_i,
  output logic                           done_o,
  output logic [lsp_pkg::CoordW-1:0]     quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            active_q, active_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic [NumW-1:0] mag_q, mag_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] dv_q, dv_d;

  logic [DivW:0]   shifted;
  logic [DivW:0]   diff;
  logic            fits;

  always_comb begin
    shifted = {rem_q, mag_q[NumW-1]};
    diff    = shifted - {1'b0, dv_q};
    fits    = shifted >= {1'b0, dv_q};

    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    rem_d    = rem_q;
    dv_d     = dv_q;

    if (start_i) begin
      neg_d    = dividend_i[NumW-1];
      mag_d    = dividend_i[NumW-1] ? NumW'(-dividend_i) : NumW'(dividend_i);
      rem_d    = '0;
      dv_d     = divisor_i;
      cnt_d    = CntW'(NumW);
      active_d = 1'b1;
    end else if (active_q) begin
      rem_d = fits ? diff[DivW-1:0] : shifted[DivW-1:0];
      mag_d = {mag_q[NumW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? lsp_pkg::CoordW'(-mag_q[lsp_pkg::CoordW-1:0])
                        : mag_q[lsp_pkg::CoordW-1:0];

endmodule

// File: hw/rtl/loop_subdivision_point_rule_core.sv
// Channel   Ports                  Direction  Transfer
// --------  ---------------------  ---------  ---------------------------------
// point     start, busy, item_i    in         edge with start high, busy low
// result    done_o, res_o          out        one cycle with done_o high
//
// Each non-closing point leaves busy low.
// A closing point (last set) raises busy; per coordinate the core then runs one
// multiply, one add, and NUM_W steps of the shared bit-serial divider, where
// NUM_W = 36 + clog2(MAX_VALENCE).
// Error jobs skip the divider.
// Reset (rst_ni low, asynchronous) clears all accumulators and the sequencer.
// The result strobe cannot be held off; busy drops in the strobe cycle.
`include "loop_subdivision_point_rule_core_defines.svh"

module loop_subdivision_point_rule_core #(
  parameter int unsigned MAX_VALENCE = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  lsp_pkg::in_item_t   item_i,
  output logic                done_o,
  output lsp_pkg::res_t       res_o
);

  localparam int unsigned CoordW = lsp_pkg::CoordW;
  localparam int unsigned EwW    = lsp_pkg::EwSumW;
  localparam int unsigned NbCntW = lsp_pkg::NbCntW;
  localparam int unsigned EwCntW = lsp_pkg::EwCntW;
  localparam int unsigned NC     = lsp_pkg::NumCoord;
  // Neighbour sum: up to MAX_VALENCE coordinates.
  localparam int unsigned SumW   = CoordW + $clog2(MAX_VALENCE);
  // Weighted numerator 5n*c + 3*S stays below 2^(SumW+3) in magnitude.
  localparam int unsigned NumW   = SumW + 4;
  localparam int unsigned KW     = $clog2(5 * MAX_VALENCE + 1);
  localparam int unsigned DivW   = $clog2(8 * MAX_VALENCE + 1);
  localparam int unsigned ProdW  = CoordW + KW + 1;
  localparam logic [1:0]  LastCoord = 2'(NC - 1);

  lsp_pkg::state_e state_q, state_d;
  lsp_pkg::job_e   job_q, job_d;

  logic signed [CoordW-1:0] centre_q  [NC];
  logic signed [CoordW-1:0] centre_d  [NC];
  logic signed [SumW-1:0]   nb_sum_q  [NC];
  logic signed [SumW-1:0]   nb_sum_d  [NC];
  logic signed [EwW-1:0]    ep_sum_q  [NC];
  logic signed [EwW-1:0]    ep_sum_d  [NC];
  logic signed [EwW-1:0]    wg_sum_q  [NC];
  logic signed [EwW-1:0]    wg_sum_d  [NC];
  logic signed [CoordW-1:0] res_q     [NC];
  logic signed [CoordW-1:0] res_d     [NC];

  logic [NbCntW-1:0] nb_cnt_q, nb_cnt_d;
  logic [EwCntW-1:0] ep_cnt_q, ep_cnt_d;
  logic [EwCntW-1:0] wg_cnt_q, wg_cnt_d;
  logic              centre_seen_q, centre_seen_d;
  logic [1:0]        coord_q, coord_d;
  logic [1:0]        status_q, status_d;
  logic              done_q, done_d;

  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [NumW-1:0]  addend_q, addend_d;
  logic [DivW-1:0]         divisor_q, divisor_d;

  logic                    accept;
  logic                    div_start;
  logic                    div_done;
  logic [CoordW-1:0]       div_quo;
  logic signed [NumW-1:0]  dividend;
  logic signed [CoordW-1:0] pt [NC];

  assign busy     = state_q != lsp_pkg::ST_ACC;
  assign accept   = start && !busy;
  assign dividend = NumW'(prod_q) + addend_q;

  assign pt[0] = item_i.px;
  assign pt[1] = item_i.py;
  assign pt[2] = item_i.pz;

  always_comb begin
    logic                   edge_roles;
    logic                   vertex_roles;
    logic                   malformed;
    logic                   bad_valence;
    logic [KW-1:0]          k;
    logic signed [NumW-1:0] ep_ext;
    logic signed [NumW-1:0] wg_ext;
    logic signed [NumW-1:0] nb_ext;
    logic                   finish;

    state_d       = state_q;
    job_d         = job_q;
    centre_d      = centre_q;
    nb_sum_d      = nb_sum_q;
    ep_sum_d      = ep_sum_q;
    wg_sum_d      = wg_sum_q;
    res_d         = res_q;
    nb_cnt_d      = nb_cnt_q;
    ep_cnt_d      = ep_cnt_q;
    wg_cnt_d      = wg_cnt_q;
    centre_seen_d = centre_seen_q;
    coord_d       = coord_q;
    status_d      = status_q;
    done_d        = 1'b0;
    prod_d        = prod_q;
    addend_d      = addend_q;
    divisor_d     = divisor_q;
    div_start     = 1'b0;
    finish        = 1'b0;

    // Job classification from the accumulated counts.
    edge_roles   = (ep_cnt_q != '0) || (wg_cnt_q != '0);
    vertex_roles = centre_seen_q || (nb_cnt_q != '0);
    malformed    = (edge_roles && vertex_roles)
                || (edge_roles && ((ep_cnt_q != EwCntW'(2))
                                   || ((wg_cnt_q != '0) && (wg_cnt_q != EwCntW'(2)))))
                || (!edge_roles && !centre_seen_q);
    bad_valence  = (nb_cnt_q < NbCntW'(2)) || (nb_cnt_q > NbCntW'(MAX_VALENCE));

    // Operands of the current coordinate.
    ep_ext = NumW'(ep_sum_q[coord_q]);
    wg_ext = NumW'(wg_sum_q[coord_q]);
    nb_ext = NumW'(nb_sum_q[coord_q]);

    unique case (job_q)
      lsp_pkg::JOB_V2: k = KW'(6);
      lsp_pkg::JOB_V3: k = KW'(7);
      lsp_pkg::JOB_VN: k = KW'({nb_cnt_q, 2'b00} + {2'b00, nb_cnt_q});
      default:         k = '0;
    endcase

    unique case (state_q)
      lsp_pkg::ST_ACC: begin
        if (accept) begin
          unique case (item_i.op)
            lsp_pkg::ROLE_CENTRE: begin
              // A repeated centre replaces the earlier one.
              for (int i = 0; i < NC; i++) centre_d[i] = pt[i];
              centre_seen_d = 1'b1;
            end
            lsp_pkg::ROLE_NEIGHBOUR: begin
              if (nb_cnt_q < NbCntW'(MAX_VALENCE)) begin
                for (int i = 0; i < NC; i++) nb_sum_d[i] = nb_sum_q[i] + SumW'(pt[i]);
              end
              if (nb_cnt_q != '1) nb_cnt_d = nb_cnt_q + NbCntW'(1);
            end
            lsp_pkg::ROLE_ENDPOINT: begin
              // Sum only the first two endpoints; keep counting the rest.
              if (!ep_cnt_q[1]) begin
                for (int i = 0; i < NC; i++) ep_sum_d[i] = ep_sum_q[i] + EwW'(pt[i]);
              end
              if (ep_cnt_q != '1) ep_cnt_d = ep_cnt_q + EwCntW'(1);
            end
            default: begin
              if (!wg_cnt_q[1]) begin
                for (int i = 0; i < NC; i++) wg_sum_d[i] = wg_sum_q[i] + EwW'(pt[i]);
              end
              if (wg_cnt_q != '1) wg_cnt_d = wg_cnt_q + EwCntW'(1);
            end
          endcase
          if (item_i.last) state_d = lsp_pkg::ST_EVAL;
        end
      end

      lsp_pkg::ST_EVAL: begin
        coord_d = '0;
        if (malformed) begin
          for (int i = 0; i < NC; i++) res_d[i] = '0;
          status_d = lsp_pkg::STATUS_MALFORMED;
          finish   = 1'b1;
        end else if (!edge_roles && bad_valence) begin
          // Pass the centre through unchanged.
          for (int i = 0; i < NC; i++) res_d[i] = centre_q[i];
          status_d = lsp_pkg::STATUS_BAD_VALENCE;
          finish   = 1'b1;
        end else begin
          status_d = lsp_pkg::STATUS_OK;
          state_d  = lsp_pkg::ST_MUL;
          priority if (edge_roles && (wg_cnt_q == '0)) begin
            job_d     = lsp_pkg::JOB_MID;
            divisor_d = DivW'(2);
          end else if (edge_roles) begin
            job_d     = lsp_pkg::JOB_WING;
            divisor_d = DivW'(8);
          end else if (nb_cnt_q == NbCntW'(2)) begin
            job_d     = lsp_pkg::JOB_V2;
            divisor_d = DivW'(8);
          end else if (nb_cnt_q == NbCntW'(3)) begin
            job_d     = lsp_pkg::JOB_V3;
            divisor_d = DivW'(16);
          end else begin
            job_d     = lsp_pkg::JOB_VN;
            divisor_d = DivW'({nb_cnt_q, 3'b000});
          end
        end
      end

      lsp_pkg::ST_MUL: begin
        // Centre weight times the centre coordinate; the other term is the sum itself or a shift-add.
        prod_d = centre_q[coord_q] * $signed({1'b0, k});
        unique case (job_q)
          lsp_pkg::JOB_MID:  addend_d = ep_ext;
          lsp_pkg::JOB_WING: addend_d = (ep_ext <<< 1) + ep_ext + wg_ext;
          lsp_pkg::JOB_V2:   addend_d = nb_ext;
          default:           addend_d = (nb_ext <<< 1) + nb_ext;
        endcase
        state_d = lsp_pkg::ST_LOAD;
      end

      lsp_pkg::ST_LOAD: begin
        div_start = 1'b1;
        state_d   = lsp_pkg::ST_DIV;
      end

      lsp_pkg::ST_DIV: begin
        if (div_done) begin
          res_d[coord_q] = div_quo;
          if (coord_q == LastCoord) begin
            finish = 1'b1;
          end else begin
            coord_d = coord_q + 2'd1;
            state_d = lsp_pkg::ST_MUL;
          end
        end
      end

      default: state_d = lsp_pkg::ST_ACC;
    endcase

    // Drop the job and show the result for one cycle.
    if (finish) begin
      done_d        = 1'b1;
      state_d       = lsp_pkg::ST_ACC;
      centre_seen_d = 1'b0;
      nb_cnt_d      = '0;
      ep_cnt_d      = '0;
      wg_cnt_d      = '0;
      for (int i = 0; i < NC; i++) begin
        centre_d[i] = '0;
        nb_sum_d[i] = '0;
        ep_sum_d[i] = '0;
        wg_sum_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= lsp_pkg::ST_ACC;
      job_q         <= lsp_pkg::JOB_MID;
      nb_cnt_q      <= '0;
      ep_cnt_q      <= '0;
      wg_cnt_q      <= '0;
      centre_seen_q <= 1'b0;
      coord_q       <= '0;
      status_q      <= '0;
      done_q        <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        centre_q[i] <= '0;
        nb_sum_q[i] <= '0;
        ep_sum_q[i] <= '0;
        wg_sum_q[i] <= '0;
      end
    end else begin
      state_q       <= state_d;
      job_q         <= job_d;
      nb_cnt_q      <= nb_cnt_d;
      ep_cnt_q      <= ep_cnt_d;
      wg_cnt_q      <= wg_cnt_d;
      centre_seen_q <= centre_seen_d;
      coord_q       <= coord_d;
      status_q      <= status_d;
      done_q        <= done_d;
      centre_q      <= centre_d;
      nb_sum_q      <= nb_sum_d;
      ep_sum_q      <= ep_sum_d;
      wg_sum_q      <= wg_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    addend_q  <= addend_d;
    divisor_q <= divisor_d;
    res_q     <= res_d;
  end

  lsp_div #(
    .NumW (NumW),
    .DivW (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign done_o        = done_q;
  assign res_o.out_x   = res_q[0];
  assign res_o.out_y   = res_q[1];
  assign res_o.out_z   = res_q[2];
  assign res_o.status  = status_q;

  `LSP_ASSERT_NOW(a_done_not_busy, done_o, !busy, "result strobe while busy")
  `LSP_ASSERT_NEXT(a_last_goes_busy, start && !busy && item_i.last, busy, "closing point did not start evaluation")
  `LSP_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe longer than one cycle")
  `LSP_ASSERT_NOW(a_div_done_in_div, div_done, state_q == lsp_pkg::ST_DIV, "divider finished outside its wait state")

endmodule

// File: bench/tb_loop_subdivision_point_rule_core.sv
module tb_loop_subdivision_point_rule_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxValence  = 32;
  localparam int          RandPoints  = 625;
  // Margin that covers the time a closing point keeps busy high.
  localparam int          DrainCycles = 200;

  // Tracks one job the way the core accumulates it and queues the refined
  // point that each closing point should produce.
  class point_rule_scoreboard;
    longint          centre_pos[3];
    longint          nb_sum[3];
    longint          ep_sum[3];
    longint          wing_sum[3];
    int              nb_cnt;
    int              ep_cnt;
    int              wing_cnt;
    bit              centre_seen;
    lsp_pkg::res_t   pending_refined[$];
    int              errors;

    function new();
      errors = 0;
      clear_job();
    endfunction

    function void clear_job();
      for (int i = 0; i < 3; i++) begin
        centre_pos[i] = 0;
        nb_sum[i]     = 0;
        ep_sum[i]     = 0;
        wing_sum[i]   = 0;
      end
      nb_cnt      = 0;
      ep_cnt      = 0;
      wing_cnt    = 0;
      centre_seen = 1'b0;
    endfunction

    // Fold one accepted point into the job; on a closing point, queue the result.
    function void note_point(lsp_pkg::in_item_t it);
      longint           p[3];
      longint           r[3];
      longint           n;
      bit               edge_roles;
      bit               vertex_roles;
      lsp_pkg::res_t    exp_res;
      lsp_pkg::status_e st;

      p[0] = longint'(it.px);
      p[1] = longint'(it.py);
      p[2] = longint'(it.pz);
      for (int i = 0; i < 3; i++) r[i] = 0;
      st = lsp_pkg::STATUS_OK;

      case (lsp_pkg::role_e'(it.op))
        lsp_pkg::ROLE_CENTRE: begin
          for (int i = 0; i < 3; i++) centre_pos[i] = p[i];
          centre_seen = 1'b1;
        end
        lsp_pkg::ROLE_NEIGHBOUR: begin
          if (nb_cnt < MaxValence)
            for (int i = 0; i < 3; i++) nb_sum[i] += p[i];
          if (nb_cnt < 127) nb_cnt++;
        end
        lsp_pkg::ROLE_ENDPOINT: begin
          if (ep_cnt < 2)
            for (int i = 0; i < 3; i++) ep_sum[i] += p[i];
          if (ep_cnt < 3) ep_cnt++;
        end
        default: begin
          if (wing_cnt < 2)
            for (int i = 0; i < 3; i++) wing_sum[i] += p[i];
          if (wing_cnt < 3) wing_cnt++;
        end
      endcase

      if (!it.last) return;

      edge_roles   = (ep_cnt != 0) || (wing_cnt != 0);
      vertex_roles = centre_seen || (nb_cnt != 0);
      n            = longint'(nb_cnt);

      if (edge_roles && vertex_roles) begin
        st = lsp_pkg::STATUS_MALFORMED;
      end else if (edge_roles) begin
        if (ep_cnt != 2 || (wing_cnt != 0 && wing_cnt != 2)) begin
          st = lsp_pkg::STATUS_MALFORMED;
        end else if (wing_cnt == 0) begin
          for (int i = 0; i < 3; i++) r[i] = ep_sum[i] / 2;
        end else begin
          for (int i = 0; i < 3; i++) r[i] = (3 * ep_sum[i] + wing_sum[i]) / 8;
        end
      end else if (!centre_seen) begin
        st = lsp_pkg::STATUS_MALFORMED;
      end else if (n < 2 || n > MaxValence) begin
        st = lsp_pkg::STATUS_BAD_VALENCE;
        for (int i = 0; i < 3; i++) r[i] = centre_pos[i];
      end else if (n == 2) begin
        for (int i = 0; i < 3; i++) r[i] = (6 * centre_pos[i] + nb_sum[i]) / 8;
      end else if (n == 3) begin
        for (int i = 0; i < 3; i++) r[i] = (7 * centre_pos[i] + 3 * nb_sum[i]) / 16;
      end else begin
        for (int i = 0; i < 3; i++)
          r[i] = (5 * n * centre_pos[i] + 3 * nb_sum[i]) / (8 * n);
      end

      exp_res.out_x  = 32'(r[0]);
      exp_res.out_y  = 32'(r[1]);
      exp_res.out_z  = 32'(r[2]);
      exp_res.status = st;
      pending_refined = {pending_refined, exp_res};
      clear_job();
    endfunction

    function void check_refined(lsp_pkg::res_t got);
      lsp_pkg::res_t exp_res;
      if (pending_refined.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      exp_res = pending_refined.pop_front();
      if (got.out_x !== exp_res.out_x) begin
        errors++;
        $display("%0t: out_x expected %h actual %h", $time, exp_res.out_x, got.out_x);
      end
      if (got.out_y !== exp_res.out_y) begin
        errors++;
        $display("%0t: out_y expected %h actual %h", $time, exp_res.out_y, got.out_y);
      end
      if (got.out_z !== exp_res.out_z) begin
        errors++;
        $display("%0t: out_z expected %h actual %h", $time, exp_res.out_z, got.out_z);
      end
      if (got.status !== exp_res.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, got.status);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start  = 1'b0;
  logic              busy;
  lsp_pkg::in_item_t item_i = '0;
  logic              done_o;
  lsp_pkg::res_t     res_o;

  point_rule_scoreboard sb = new();

  lsp_pkg::in_item_t job_points[$];
  int                points_sent;
  bit                no_idle;

  loop_subdivision_point_rule_core #(
    .MAX_VALENCE(MaxValence)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .item_i(item_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Results cannot be held off: take every strobe at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_refined(res_o);
  end

  // Lean toward the extremes and sign boundaries, otherwise full range.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'($urandom_range(0, 255)) << 16;
      4: return -(32'($urandom_range(0, 255)) << 16);
      default: return $urandom();
    endcase
  endfunction

  function automatic lsp_pkg::in_item_t mk_point(lsp_pkg::role_e role, logic [31:0] x,
                                                 logic [31:0] y, logic [31:0] z,
                                                 logic last);
    lsp_pkg::in_item_t it;
    it.op   = role;
    it.px   = x;
    it.py   = y;
    it.pz   = z;
    it.last = last;
    return it;
  endfunction

  // Add one point at the tail of the job.
  function automatic void append_point(lsp_pkg::role_e role, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z, logic last);
    job_points = {job_points, mk_point(role, x, y, z, last)};
  endfunction

  // Hold start high across back-to-back transfers; drop it only for a gap.
  task automatic send_point(input lsp_pkg::in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_point(it);
    points_sent++;
  endtask

  task automatic send_job_points();
    foreach (job_points[i]) send_point(job_points[i]);
    job_points.delete();
  endtask

  // Fill the job with the given role counts in random order; close on the final point.
  task automatic build_job(input int n_c, input int n_n, input int n_e, input int n_w);
    int                j;
    lsp_pkg::in_item_t tmp;
    for (int i = 0; i < n_c; i++)
      append_point(lsp_pkg::ROLE_CENTRE, rand_coord(), rand_coord(), rand_coord(), 1'b0);
    for (int i = 0; i < n_n; i++)
      append_point(lsp_pkg::ROLE_NEIGHBOUR, rand_coord(), rand_coord(), rand_coord(), 1'b0);
    for (int i = 0; i < n_e; i++)
      append_point(lsp_pkg::ROLE_ENDPOINT, rand_coord(), rand_coord(), rand_coord(), 1'b0);
    for (int i = 0; i < n_w; i++)
      append_point(lsp_pkg::ROLE_WING, rand_coord(), rand_coord(), rand_coord(), 1'b0);
    for (int i = job_points.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = job_points[i];
      job_points[i] = job_points[j];
      job_points[j] = tmp;
    end
    if (job_points.size() != 0) job_points[job_points.size() - 1].last = 1'b1;
  endtask

  function automatic int pick_valence();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 1);
    if (r <= 12) return $urandom_range(2, 6);
    if (r <= 16) return $urandom_range(7, MaxValence);
    if (r <= 18) return $urandom_range(MaxValence + 1, MaxValence + 3);
    return MaxValence;
  endfunction

  task automatic run_directed();
    // Edge midpoint at the coordinate extremes.
    append_point(lsp_pkg::ROLE_ENDPOINT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    append_point(lsp_pkg::ROLE_ENDPOINT, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 1'b1);
    // Edge with two wings, interleaved.
    append_point(lsp_pkg::ROLE_ENDPOINT, 32'h7fff_ffff, 32'h8000_0000, 32'd5, 1'b0);
    append_point(lsp_pkg::ROLE_WING, 32'h8000_0000, 32'h7fff_ffff, -32'sd7, 1'b0);
    append_point(lsp_pkg::ROLE_ENDPOINT, 32'h7fff_ffff, 32'h8000_0000, 32'd3, 1'b0);
    append_point(lsp_pkg::ROLE_WING, 32'd3, 32'hffff_ffff, 32'h0001_0000, 1'b1);
    // Boundary vertex, two neighbours.
    append_point(lsp_pkg::ROLE_CENTRE, 32'h8000_0000, 32'h7fff_ffff, -32'sd1, 1'b0);
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'h7fff_ffff, 32'h8000_0000, 32'd9, 1'b0);
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'h8000_0000, 32'h8000_0000, -32'sd9, 1'b1);
    // Valence three with the centre in the middle of the stream.
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'h7fff_ffff, 32'd1, -32'sd5, 1'b0);
    append_point(lsp_pkg::ROLE_CENTRE, 32'h7fff_ffff, -32'sd3, 32'h8000_0000, 1'b0);
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'h7fff_ffff, 32'd2, 32'h8000_0000, 1'b0);
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'h7fff_ffff, 32'd7, 32'h8000_0000, 1'b1);
    // Bad valence: one neighbour, centre passes through.
    append_point(lsp_pkg::ROLE_CENTRE, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'd1, 32'd2, 32'd3, 1'b1);
    // Centre alone.
    append_point(lsp_pkg::ROLE_CENTRE, 32'hdead_beef, 32'h0000_0000, 32'hffff_ffff, 1'b1);
    // Neighbours with no centre.
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'd10, 32'd20, 32'd30, 1'b0);
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'd40, 32'd50, 32'd60, 1'b1);
    // Mixed job: centre plus an endpoint.
    append_point(lsp_pkg::ROLE_CENTRE, 32'd100, 32'd200, 32'd300, 1'b0);
    append_point(lsp_pkg::ROLE_ENDPOINT, 32'd1, 32'd2, 32'd3, 1'b1);
    // Repeated centre: the later one wins.
    append_point(lsp_pkg::ROLE_CENTRE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    append_point(lsp_pkg::ROLE_CENTRE, 32'hffff_0000, 32'h0003_8000, -32'sd17, 1'b0);
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'h0001_0000, 32'hfffe_0000, 32'd11, 1'b0);
    append_point(lsp_pkg::ROLE_NEIGHBOUR, 32'h0005_0000, 32'h0000_0001, 32'd13, 1'b1);
    send_job_points();
  endtask

  task automatic run_random();
    int kind;
    int start_count;
    start_count = points_sent;
    // One job that drives the neighbour count into saturation.
    no_idle = 1'b1;
    build_job(1, 130, 0, 0);
    send_job_points();
    while (points_sent - start_count < RandPoints) begin
      no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        build_job(0, 0, 2, $urandom_range(0, 1) ? 2 : 0);
      end else if (kind < 75) begin
        build_job(($urandom_range(0, 6) == 0) ? 2 : 1, pick_valence(), 0, 0);
      end else if (kind < 85) begin
        // Broken edge: wrong endpoint or wing count.
        if ($urandom_range(0, 1))
          build_job(0, 0, $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(3, 4),
                    $urandom_range(0, 1) ? 2 : 0);
        else
          build_job(0, 0, 2, $urandom_range(0, 1) ? 1 : $urandom_range(3, 4));
      end else if (kind < 92) begin
        // Mixed roles, or neighbours with no centre.
        if ($urandom_range(0, 1))
          build_job($urandom_range(0, 1), $urandom_range(0, 4),
                    $urandom_range(1, 2), $urandom_range(0, 2));
        else
          build_job(0, $urandom_range(1, 5), 0, 0);
      end else begin
        build_job($urandom_range(0, 2), $urandom_range(0, 3),
                  $urandom_range(0, 3), $urandom_range(0, 3));
      end
      send_job_points();
    end
  endtask

  initial begin
    points_sent = 0;
    no_idle     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random();
    start <= 1'b0;

    // Drain: wait for every queued result, then let the sequencer settle.
    while (sb.pending_refined.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_refined.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
